FILE: rtl/fua_pkg.sv
// fua_pkg: types, constants and register codes of the h.264 fu-a packetizer
// used by fua_cfg, fua_step, fua_out and the top; depends on nothing
`default_nettype none

package fua_pkg;

  // nal unit length field
  localparam int DEF_LENGTH_BITS = 20;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int PAYLOAD_W  = 16;
  localparam int TS_STEP_W  = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_STEP = 2'd1;

  localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST    = 16'd1400;
  localparam logic [TS_STEP_W-1:0] TS_STEP_RST        = 17'd3600;
  localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_LIMIT  = 16'd65533;

  // nal header masks and fu-a codes
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
  localparam logic [7:0] NAL_TYPE_FUA  = 8'd28;
  localparam logic [7:0] FU_START_BIT  = 8'h80;
  localparam logic [7:0] FU_END_BIT    = 8'h40;
  localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
  localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;

  // fu-a packets carry indicator and header in front of the data
  localparam logic [PAYLOAD_W-1:0] FU_OVERHEAD = 16'd2;

  // one output word
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] packet_length;
    logic [15:0] seq_number;
    logic [31:0] rtp_time;
    logic        run_last;
  } fua_word_t;

  // the words caused by one input byte, up to three
  typedef struct packed {
    logic [1:0]          count;
    fua_word_t [2:0]     words;
  } fua_group_t;

  // effective configuration handed to the step logic
  typedef struct packed {
    logic [PAYLOAD_W-1:0] max_payload;
    logic [TS_STEP_W-1:0] timestamp_step;
  } fua_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/fua_if.sv
// fua_in_if and fua_out_if: valid/ready channels of the packetizer
// nal byte input channel and payload word output channel; no dependencies
`default_nettype none

interface fua_in_if #(
  parameter int LB = 20
);
  logic          valid;
  logic          ready;
  logic [7:0]    nal_byte;
  logic [LB-1:0] nal_length;

  modport source (output valid, output nal_byte, output nal_length, input ready);
  modport sink   (input valid, input nal_byte, input nal_length, output ready);
endinterface

interface fua_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        packet_first;
  logic        packet_last;
  logic [15:0] packet_length;
  logic [15:0] seq_number;
  logic [31:0] rtp_time;
  logic        run_last;

  modport source (output valid, output out_byte, output packet_first,
                  output packet_last, output packet_length, output seq_number,
                  output rtp_time, output run_last, input ready);
  modport sink   (input valid, input out_byte, input packet_first,
                  input packet_last, input packet_length, input seq_number,
                  input rtp_time, input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/fua_cfg.sv
// fua_cfg: configuration registers, max_payload stored already clamped
// depends on fua_pkg
`default_nettype none

module fua_cfg
  import fua_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output fua_cfg_t                   cfg_o
);

  logic [PAYLOAD_W-1:0] max_payload_q, max_payload_d;
  logic [TS_STEP_W-1:0] ts_step_q, ts_step_d;
  logic [PAYLOAD_W-1:0] wr_payload;

  // clamp the payload limit to 1..65533 on write
  always_comb begin
    wr_payload = cfg_data_i[PAYLOAD_W-1:0];
    if (wr_payload == '0) begin
      wr_payload = PAYLOAD_W'(1);
    end else if (wr_payload > MAX_PAYLOAD_LIMIT) begin
      wr_payload = MAX_PAYLOAD_LIMIT;
    end
  end

  // register write decode
  always_comb begin
    max_payload_d = max_payload_q;
    ts_step_d     = ts_step_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_PAYLOAD:    max_payload_d = wr_payload;
        CFG_TIMESTAMP_STEP: ts_step_d     = cfg_data_i[TS_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
      ts_step_q     <= TS_STEP_RST;
    end else begin
      max_payload_q <= max_payload_d;
      ts_step_q     <= ts_step_d;
    end
  end

  assign cfg_o.max_payload    = max_payload_q;
  assign cfg_o.timestamp_step = ts_step_q;

endmodule

`default_nettype wire

FILE: rtl/fua_step.sv
// fua_step: unit and fragment state, builds the words caused by one nal byte
// depends on fua_pkg and fua_in_if
`default_nettype none

module fua_step
  import fua_pkg::*;
#(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fua_in_if.sink      nal_i,
  input  fua_cfg_t    cfg_i,
  input  wire logic   load_ready_i,
  output logic        load_o,
  output fua_group_t  group_o
);

  localparam int LB = LENGTH_BITS;
  localparam int CW = (LB > PAYLOAD_W) ? LB : PAYLOAD_W;

  // state registers
  logic [LB-1:0]        pos_q, pos_d;
  logic [LB-1:0]        ulen_q, ulen_d;
  logic [7:0]           hdr_q, hdr_d;
  logic                 fmode_q, fmode_d;
  logic [PAYLOAD_W-1:0] fill_q, fill_d;
  logic                 ffp_q, ffp_d;
  logic [PAYLOAD_W-1:0] psize_q, psize_d;
  logic [15:0]          seq_q, seq_d;
  logic [31:0]          time_q, time_d;

  // step values
  logic                 accept;
  logic                 pos0;
  logic [LB-1:0]        ulen;
  logic [7:0]           hdr;
  logic                 fmode;
  logic [PAYLOAD_W-1:0] fill;
  logic                 ffp;
  logic [CW-1:0]        ulen_w;
  logic [CW-1:0]        rem_w;
  logic [CW-1:0]        m_w;
  logic                 unit_end;
  logic                 start_frag;
  logic [PAYLOAD_W-1:0] flen_new;
  logic [PAYLOAD_W-1:0] psize;
  logic [PAYLOAD_W-1:0] flen;
  logic [PAYLOAD_W-1:0] fill_inc;
  logic                 frag_close;
  logic [7:0]           fu_hdr;
  logic [7:0]           fu_ind;
  logic [7:0]           nal_type;
  logic                 seq_inc;
  logic                 adv_time;
  fua_word_t            data_w;
  fua_word_t            ind_w;
  fua_word_t            fuh_w;

  assign accept       = nal_i.valid && load_ready_i;
  assign nal_i.ready  = load_ready_i;

  // unit fields: sampled on the header byte, held afterwards
  always_comb begin
    pos0  = (pos_q == '0);
    ulen  = ulen_q;
    hdr   = hdr_q;
    fill  = fill_q;
    ffp   = ffp_q;
    if (pos0) begin
      ulen = (nal_i.nal_length == '0) ? LB'(1) : nal_i.nal_length;
      hdr  = nal_i.nal_byte;
      fill = '0;
      ffp  = 1'b1;
    end
  end

  assign ulen_w   = CW'(ulen);
  assign m_w      = CW'(cfg_i.max_payload);
  assign rem_w    = CW'(ulen - pos_q);
  assign fmode    = pos0 ? (ulen_w > m_w) : fmode_q;
  assign unit_end = (({1'b0, pos_q} + (LB+1)'(1)) >= {1'b0, ulen});

  // fragment sizing
  assign start_frag = fmode && !pos0 && (fill == '0);
  assign flen_new   = (rem_w < m_w) ? rem_w[PAYLOAD_W-1:0] : cfg_i.max_payload;

  always_comb begin
    psize = psize_q;
    if (pos0 && !fmode) begin
      psize = ulen_w[PAYLOAD_W-1:0];
    end else if (start_frag) begin
      psize = flen_new + FU_OVERHEAD;
    end
  end

  assign flen       = psize - FU_OVERHEAD;
  assign fill_inc   = fill + PAYLOAD_W'(1);
  assign frag_close = (fill_inc >= flen) || unit_end;

  // fu-a indicator and header bytes
  assign nal_type = hdr & NAL_TYPE_MASK;
  assign fu_ind   = (hdr & NAL_NRI_MASK) | NAL_TYPE_FUA;
  assign fu_hdr   = nal_type | (ffp ? FU_START_BIT : 8'h00)
                  | ((rem_w <= m_w) ? FU_END_BIT : 8'h00);

  // word templates
  always_comb begin
    data_w.out_byte      = nal_i.nal_byte;
    data_w.packet_first  = !fmode && pos0;
    data_w.packet_last   = fmode ? frag_close : unit_end;
    data_w.packet_length = psize;
    data_w.seq_number    = seq_q;
    data_w.rtp_time      = time_q;
    data_w.run_last      = 1'b1;

    ind_w               = data_w;
    ind_w.out_byte      = fu_ind;
    ind_w.packet_first  = 1'b1;
    ind_w.packet_last   = 1'b0;
    ind_w.run_last      = 1'b0;

    fuh_w               = ind_w;
    fuh_w.out_byte      = fu_hdr;
    fuh_w.packet_first  = 1'b0;
  end

  // word group and counter effects
  always_comb begin
    group_o.count    = 2'd0;
    group_o.words[0] = data_w;
    group_o.words[1] = data_w;
    group_o.words[2] = data_w;
    seq_inc          = 1'b0;
    adv_time         = 1'b1;
    if (!fmode) begin
      group_o.count = 2'd1;
      seq_inc       = unit_end;
      if (nal_type == NAL_TYPE_SPS || nal_type == NAL_TYPE_PPS) begin
        adv_time = 1'b0;
      end
    end else if (!pos0) begin
      seq_inc = frag_close;
      if (start_frag) begin
        group_o.count    = 2'd3;
        group_o.words[0] = ind_w;
        group_o.words[1] = fuh_w;
      end else begin
        group_o.count    = 2'd1;
      end
    end
  end

  assign load_o = accept;

  // next state
  always_comb begin
    ulen_d  = ulen;
    hdr_d   = hdr;
    psize_d = psize;
    seq_d   = seq_inc ? (seq_q + 16'd1) : seq_q;
    time_d  = time_q;
    if (unit_end) begin
      pos_d   = '0;
      fmode_d = 1'b0;
      fill_d  = '0;
      ffp_d   = 1'b1;
      if (adv_time) begin
        time_d = time_q + 32'(cfg_i.timestamp_step);
      end
    end else begin
      pos_d   = pos_q + LB'(1);
      fmode_d = fmode;
      fill_d  = (fmode && !pos0) ? (frag_close ? '0 : fill_inc) : fill;
      ffp_d   = start_frag ? 1'b0 : ffp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ulen_q  <= '0;
      hdr_q   <= '0;
      fmode_q <= 1'b0;
      fill_q  <= '0;
      ffp_q   <= 1'b1;
      psize_q <= '0;
      seq_q   <= '0;
      time_q  <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      ulen_q  <= ulen_d;
      hdr_q   <= hdr_d;
      fmode_q <= fmode_d;
      fill_q  <= fill_d;
      ffp_q   <= ffp_d;
      psize_q <= psize_d;
      seq_q   <= seq_d;
      time_q  <= time_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fua_out.sv
// fua_out: result register holding up to three words, sent one per cycle while pkt_o is ready
// depends on fua_pkg and fua_out_if
`default_nettype none

module fua_out
  import fua_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  fua_group_t group_i,
  output logic       load_ready_o,
  fua_out_if.source  pkt_o
);

  fua_word_t [2:0] words_q, words_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign pop          = pkt_o.valid && pkt_o.ready;
  // room for a new group when empty or the last word leaves now
  assign load_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pkt_o.ready);

  // load or shift
  always_comb begin
    words_d = words_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      words_d = group_i.words;
      cnt_d   = group_i.count;
    end else if (pop) begin
      words_d[0] = words_q[1];
      words_d[1] = words_q[2];
      cnt_d      = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  // head word to the port
  assign pkt_o.valid         = (cnt_q != 2'd0);
  assign pkt_o.out_byte      = words_q[0].out_byte;
  assign pkt_o.packet_first  = words_q[0].packet_first;
  assign pkt_o.packet_last   = words_q[0].packet_last;
  assign pkt_o.packet_length = words_q[0].packet_length;
  assign pkt_o.seq_number    = words_q[0].seq_number;
  assign pkt_o.rtp_time      = words_q[0].rtp_time;
  assign pkt_o.run_last      = words_q[0].run_last;

endmodule

`default_nettype wire

FILE: rtl/h264_fua_packetizer_top.sv
// h264_fua_packetizer_top: h.264 nal unit to rtp payload packetizer, single nal unit or fu-a
// depends on fua_pkg, fua_if, fua_cfg, fua_step and fua_out
//
//   channel   dir  handshake          payload
//   nal_i     in   valid/ready        nal_byte, nal_length
//   pkt_o     out  valid/ready        out_byte, packet_first, packet_last,
//                                     packet_length, seq_number, rtp_time,
//                                     run_last
//   cfg       in   cfg_we_i, no wait  cfg_idx_i, cfg_data_i
//
// a nal byte is taken and its words appear the next cycle; a byte that
// gives one word sustains one byte per cycle while pkt_o is ready, a
// fragmented unit's header byte gives none, and a byte that opens a
// fragment gives three words and holds the input until the last leaves.
// reset clears all unit, sequence and timestamp state, no clearing pass.
// a stalled output holds its word; input is taken once the last queued
// word leaves.
`default_nettype none

module h264_fua_packetizer_top
  import fua_pkg::*;
#(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  fua_in_if.sink                     nal_i,
  fua_out_if.source                  pkt_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  fua_cfg_t   cfg;
  fua_group_t group;
  logic       load;
  logic       load_ready;

  fua_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fua_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nal_i        (nal_i),
    .cfg_i        (cfg),
    .load_ready_i (load_ready),
    .load_o       (load),
    .group_o      (group)
  );

  fua_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .group_i      (group),
    .load_ready_o (load_ready),
    .pkt_o        (pkt_o)
  );

endmodule

`default_nettype wire
